FILE: sv/cf_pkg.sv
// ----------------------------------------------------------------------------
// cf_pkg
// Shared widths, register codes and controller/datapath bundles for the
// cosine collaborative filter.
// ----------------------------------------------------------------------------
package cf_pkg;

  localparam int DEF_MAX_USERS  = 64;
  localparam int DEF_MAX_MOVIES = 64;
  localparam int MAX_RESULTS    = 64;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam int TGT_W     = 6;
  localparam int RATING_W  = 8;
  localparam int CNT_W     = 7;
  localparam int LC_W      = 14;
  localparam int ACC_W     = 23;
  localparam int PROD_W    = 46;
  localparam int ROOT_W    = 23;
  localparam int DIV_NW    = 40;
  localparam int DIV_DW    = 24;
  localparam int SIM_W     = 17;
  localparam int SCORE_W   = 16;
  localparam int IDX_W     = 6;
  localparam int WS_W      = 32;
  localparam int SS_W      = 24;

  localparam logic [SIM_W-1:0]   SIM_ONE   = 17'h10000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_TOP_N  = 2'd1,
    CFG_USERS  = 2'd2,
    CFG_MOVIES = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
  } pl_entry_t;

  typedef struct packed {
    logic load_en;
    logic run_init;
    logic sim_acc;
    logic mul_lo;
    logic mul_hi;
    logic sq_start;
    logic div_sim;
    logic div_pr;
    logic sim_wr;
    logic m_inc;
    logic pr_clr;
    logic pr_acc;
    logic p_zero;
    logic p_take;
    logic ins_init;
    logic ins_shift;
    logic ins_put;
    logic list_out;
    logic out_init;
    logic out_load;
    logic out_empty;
    logic out_next;
  } cf_cmd_t;

  typedef struct packed {
    logic load_done;
    logic t_bad;
    logic m_last;
    logic u_last;
    logic norm_zero;
    logic t_rated;
    logic ss_zero;
    logic sq_done;
    logic div_done;
    logic i_zero;
    logic ins_less;
    logic cnt_zero;
    logic out_acc;
    logic out_last;
  } cf_sts_t;

  // zero acts as one, larger values saturate
  function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] v, int hi);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > hi) begin
      r = CNT_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: sv/cf_isqrt.sv
// ----------------------------------------------------------------------------
// cf_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cf_isqrt import cf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int StepW = $clog2(ROOT_W);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [PROD_W-1:0] v_q;
  logic [ROOT_W+1:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W+3:0] rem_t, trial;
  logic              ge;

  assign rem_t = {rem_q, v_q[PROD_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      v_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(ROOT_W - 1);
        v_q    <= value_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        v_q    <= {v_q[PROD_W-3:0], 2'b00};
        rem_q  <= ge ? (ROOT_W+2)'(rem_t - trial) : (ROOT_W+2)'(rem_t);
        root_q <= {root_q[ROOT_W-2:0], ge};
        step_q <= step_q - StepW'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: sv/cf_div.sv
// ----------------------------------------------------------------------------
// cf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cf_div import cf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [DIV_DW-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quotient_o
);

  localparam int StepW = $clog2(DIV_NW);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [DIV_NW-1:0] dvd_q;
  logic [DIV_DW-1:0] dsr_q, rem_q;
  logic [DIV_DW:0]   part, dsr_x;
  logic              ge;

  assign part  = {rem_q, dvd_q[DIV_NW-1]};
  assign dsr_x = {1'b0, dsr_q};
  assign ge    = part >= dsr_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(DIV_NW - 1);
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= ge ? DIV_DW'(part - dsr_x) : part[DIV_DW-1:0];
        dvd_q  <= {dvd_q[DIV_NW-2:0], ge};
        step_q <= step_q - StepW'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

FILE: sv/cf_dp.sv
// ----------------------------------------------------------------------------
// cf_dp
// Datapath: configuration, rating memory, similarity and prediction
// accumulators, sorted prediction list and output register.
// ----------------------------------------------------------------------------
module cf_dp import cf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [RATING_W-1:0]  rating_i,
  input  logic                 out_stall_i,
  input  cf_cmd_t              cmd_i,
  output cf_sts_t              sts_o,
  output logic                 out_valid_o,
  output logic [IDX_W-1:0]     movie_index_o,
  output logic [SCORE_W-1:0]   predicted_score_o,
  output logic                 empty_res_o,
  output logic                 last_result_o
);

  localparam int Depth    = DEF_MAX_USERS * DEF_MAX_MOVIES;
  localparam int AddrW    = $clog2(Depth);
  localparam int UserIdxW = $clog2(DEF_MAX_USERS);
  localparam int ListIdxW = (DEF_MAX_MOVIES > 1) ? $clog2(DEF_MAX_MOVIES) : 1;

  // configuration
  logic [TGT_W-1:0] target_q;
  logic [CNT_W-1:0] topn_q, users_q, movies_q;
  logic [CNT_W-1:0] uc, mc, tn, ocount;
  logic [LC_W-1:0]  total, load_q;
  logic             in_take, load_last;

  assign uc    = clamp_cnt(users_q, DEF_MAX_USERS);
  assign mc    = clamp_cnt(movies_q, DEF_MAX_MOVIES);
  assign tn    = clamp_cnt(topn_q, MAX_RESULTS);
  assign total = LC_W'(uc) * LC_W'(mc);

  assign in_take   = in_valid_i & cmd_i.load_en;
  assign load_last = load_q == (total - LC_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      topn_q   <= CNT_W'(1);
      users_q  <= CNT_W'(1);
      movies_q <= CNT_W'(1);
      load_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TARGET: target_q <= cfg_data_i[TGT_W-1:0];
        CFG_TOP_N:  topn_q   <= cfg_data_i;
        CFG_USERS:  users_q  <= cfg_data_i;
        CFG_MOVIES: movies_q <= cfg_data_i;
        default:    target_q <= target_q;
      endcase
      load_q <= '0;
    end else if (in_take) begin
      load_q <= load_last ? '0 : load_q + LC_W'(1);
    end
  end

  // loop counters and accumulators
  logic [CNT_W-1:0]   m_q, u_q, i_q, cnt_q, o_q;
  logic [LC_W-1:0]    t_base_q, row_u_q;
  logic [ACC_W-1:0]   dot_q, na_q, nb_q;
  logic [PROD_W-1:0]  prod_q;
  logic [WS_W-1:0]    ws_q;
  logic [SS_W-1:0]    ss_q;
  logic [SCORE_W-1:0] p_q;

  logic [RATING_W-1:0] ra_q, rb_q;
  logic [SIM_W-1:0]    sim_rd_q;
  pl_entry_t           list_rd_q;

  logic [AddrW-1:0]      addr_a, addr_b;
  logic [ListIdxW-1:0]   laddr;
  logic [2*RATING_W-1:0] p_ab, p_aa, p_bb;
  logic [34:0]           pp_lo;
  logic [33:0]           pp_hi;
  logic [SIM_W+RATING_W-1:0] wprod;
  logic                  use_rating;

  assign addr_a = AddrW'(t_base_q + LC_W'(m_q));
  assign addr_b = AddrW'(row_u_q + LC_W'(m_q));
  assign laddr  = cmd_i.list_out ? ListIdxW'(o_q) : ListIdxW'(i_q - CNT_W'(1));

  assign p_ab  = (2*RATING_W)'(ra_q) * (2*RATING_W)'(rb_q);
  assign p_aa  = (2*RATING_W)'(ra_q) * (2*RATING_W)'(ra_q);
  assign p_bb  = (2*RATING_W)'(rb_q) * (2*RATING_W)'(rb_q);
  // norm product split into two partial products, low half then high half
  assign pp_lo = 35'(na_q) * 35'(nb_q[11:0]);
  assign pp_hi = 34'(na_q) * 34'(nb_q[ACC_W-1:12]);
  assign wprod = (SIM_W+RATING_W)'(sim_rd_q) * (SIM_W+RATING_W)'(rb_q);
  assign use_rating = (u_q != CNT_W'(target_q)) && (rb_q != '0);

  // iterative square root and shared divider
  logic [ROOT_W-1:0] root;
  logic [DIV_NW-1:0] quo, dividend;
  logic [DIV_DW-1:0] divisor;
  logic              sq_done, div_done;

  assign dividend = cmd_i.div_sim ? {1'b0, dot_q, 16'h0000} : {ws_q, 8'h00};
  assign divisor  = cmd_i.div_sim ? {1'b0, root} : ss_q;

  cf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .value_i (prod_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  cf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_sim | cmd_i.div_pr),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic             norm_zero;
  logic [SIM_W-1:0] sim_val;

  assign norm_zero = (na_q == '0) || (nb_q == '0);
  always_comb begin
    if (norm_zero) begin
      sim_val = '0;
    end else if (quo > DIV_NW'(SIM_ONE)) begin
      sim_val = SIM_ONE;
    end else begin
      sim_val = quo[SIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q      <= '0;
      u_q      <= '0;
      i_q      <= '0;
      cnt_q    <= '0;
      o_q      <= '0;
      t_base_q <= '0;
      row_u_q  <= '0;
    end else begin
      if (cmd_i.run_init) begin
        t_base_q <= LC_W'(target_q) * LC_W'(mc);
        u_q      <= '0;
        row_u_q  <= '0;
        m_q      <= '0;
        cnt_q    <= '0;
      end
      if (cmd_i.sim_acc || cmd_i.m_inc) begin
        m_q <= m_q + CNT_W'(1);
      end
      if (cmd_i.sim_wr || cmd_i.pr_acc) begin
        u_q     <= u_q + CNT_W'(1);
        row_u_q <= row_u_q + LC_W'(mc);
      end
      if (cmd_i.sim_wr) begin
        m_q <= '0;
      end
      if (cmd_i.pr_clr) begin
        u_q     <= '0;
        row_u_q <= '0;
      end
      if (cmd_i.ins_init) begin
        i_q <= cnt_q;
      end
      if (cmd_i.ins_shift) begin
        i_q <= i_q - CNT_W'(1);
      end
      if (cmd_i.ins_put) begin
        cnt_q <= cnt_q + CNT_W'(1);
        m_q   <= m_q + CNT_W'(1);
      end
      if (cmd_i.out_init) begin
        o_q <= '0;
      end
      if (cmd_i.out_next) begin
        o_q <= o_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init || cmd_i.sim_wr) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.sim_acc) begin
      dot_q <= dot_q + ACC_W'(p_ab);
      na_q  <= na_q + ACC_W'(p_aa);
      nb_q  <= nb_q + ACC_W'(p_bb);
    end
    if (cmd_i.mul_lo) begin
      prod_q <= PROD_W'(pp_lo);
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + {pp_hi, 12'h000};
    end
    if (cmd_i.pr_clr) begin
      ws_q <= '0;
      ss_q <= '0;
    end else if (cmd_i.pr_acc && use_rating) begin
      ws_q <= ws_q + WS_W'(wprod);
      ss_q <= ss_q + SS_W'(sim_rd_q);
    end
    if (cmd_i.p_zero) begin
      p_q <= '0;
    end else if (cmd_i.p_take) begin
      p_q <= (quo > DIV_NW'(SCORE_MAX)) ? SCORE_MAX : quo[SCORE_W-1:0];
    end
  end

  // memories
  logic [RATING_W-1:0] rating_mem [Depth];
  logic [SIM_W-1:0]    sim_mem [DEF_MAX_USERS];
  pl_entry_t           list_mem [DEF_MAX_MOVIES];

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rating_mem[AddrW'(load_q)] <= rating_i;
    end
    ra_q <= rating_mem[addr_a];
    rb_q <= rating_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sim_wr) begin
      sim_mem[UserIdxW'(u_q)] <= sim_val;
    end
    sim_rd_q <= sim_mem[UserIdxW'(u_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_shift) begin
      list_mem[ListIdxW'(i_q)] <= list_rd_q;
    end else if (cmd_i.ins_put) begin
      list_mem[ListIdxW'(i_q)] <= '{idx: m_q[IDX_W-1:0], score: p_q};
    end
    list_rd_q <= list_mem[laddr];
  end

  // output register
  logic out_valid_q, out_acc;

  assign out_acc = out_valid_q & ~out_stall_i;
  assign ocount  = (cnt_q < tn) ? cnt_q : tn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q       <= 1'b0;
      movie_index_o     <= '0;
      predicted_score_o <= '0;
      empty_res_o       <= 1'b0;
      last_result_o     <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q       <= 1'b1;
      movie_index_o     <= list_rd_q.idx;
      predicted_score_o <= list_rd_q.score;
      empty_res_o       <= 1'b0;
      last_result_o     <= (o_q + CNT_W'(1)) == ocount;
    end else if (cmd_i.out_empty) begin
      out_valid_q       <= 1'b1;
      movie_index_o     <= '0;
      predicted_score_o <= '0;
      empty_res_o       <= 1'b1;
      last_result_o     <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.load_done = in_take & load_last;
    sts_o.t_bad     = CNT_W'(target_q) >= uc;
    sts_o.m_last    = m_q == (mc - CNT_W'(1));
    sts_o.u_last    = u_q == (uc - CNT_W'(1));
    sts_o.norm_zero = norm_zero;
    sts_o.t_rated   = ra_q != '0;
    sts_o.ss_zero   = ss_q == '0;
    sts_o.sq_done   = sq_done;
    sts_o.div_done  = div_done;
    sts_o.i_zero    = i_q == '0;
    sts_o.ins_less  = list_rd_q.score < p_q;
    sts_o.cnt_zero  = cnt_q == '0;
    sts_o.out_acc   = out_acc;
    sts_o.out_last  = last_result_o;
  end

endmodule

FILE: sv/cf_ctrl.sv
// ----------------------------------------------------------------------------
// cf_ctrl
// Sequencer for loading, similarity, prediction, insertion sort and output.
// ----------------------------------------------------------------------------
module cf_ctrl import cf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cf_sts_t sts_i,
  output cf_cmd_t cmd_o
);

  typedef enum logic [21:0] {
    S_LOAD     = 22'h000001,
    S_START    = 22'h000002,
    S_SIM_RD   = 22'h000004,
    S_SIM_ACC  = 22'h000008,
    S_MUL_LO   = 22'h000010,
    S_MUL_HI   = 22'h000020,
    S_SQ_GO    = 22'h000040,
    S_SQ_WAIT  = 22'h000080,
    S_DS_GO    = 22'h000100,
    S_DS_WAIT  = 22'h000200,
    S_SIM_WR   = 22'h000400,
    S_PR_TRD   = 22'h000800,
    S_PR_TCHK  = 22'h001000,
    S_PR_RD    = 22'h002000,
    S_PR_ACC   = 22'h004000,
    S_PR_DIV   = 22'h008000,
    S_DP_WAIT  = 22'h010000,
    S_INS_INIT = 22'h020000,
    S_INS_CHK  = 22'h040000,
    S_INS_CMP  = 22'h080000,
    S_INS_PUT  = 22'h100000,
    S_OUT      = 22'h200000
  } state_e;

  // output sub-phases share one state, told apart by a small step register
  typedef enum logic [4:0] {
    O_INIT  = 5'b00001,
    O_RD    = 5'b00010,
    O_LD    = 5'b00100,
    O_EMPTY = 5'b01000,
    O_WAIT  = 5'b10000
  } out_step_e;

  state_e    state_q, state_d;
  out_step_e ostep_q, ostep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ostep_q <= O_INIT;
    end else begin
      state_q <= state_d;
      ostep_q <= ostep_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ostep_d = ostep_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        cmd_o.load_en = 1'b1;
        if (sts_i.load_done) begin
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.run_init = 1'b1;
        if (sts_i.t_bad) begin
          state_d = S_OUT;
          ostep_d = O_EMPTY;
        end else begin
          state_d = S_SIM_RD;
        end
      end
      S_SIM_RD: state_d = S_SIM_ACC;
      S_SIM_ACC: begin
        cmd_o.sim_acc = 1'b1;
        state_d = sts_i.m_last ? S_MUL_LO : S_SIM_RD;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = sts_i.norm_zero ? S_SIM_WR : S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd_o.sq_start = 1'b1;
        state_d = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts_i.sq_done) begin
          state_d = S_DS_GO;
        end
      end
      S_DS_GO: begin
        cmd_o.div_sim = 1'b1;
        state_d = S_DS_WAIT;
      end
      S_DS_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_SIM_WR;
        end
      end
      S_SIM_WR: begin
        cmd_o.sim_wr = 1'b1;
        state_d = sts_i.u_last ? S_PR_TRD : S_SIM_RD;
      end
      S_PR_TRD: state_d = S_PR_TCHK;
      S_PR_TCHK: begin
        if (sts_i.t_rated) begin
          cmd_o.m_inc = 1'b1;
          if (sts_i.m_last) begin
            state_d = S_OUT;
            ostep_d = O_INIT;
          end else begin
            state_d = S_PR_TRD;
          end
        end else begin
          cmd_o.pr_clr = 1'b1;
          state_d = S_PR_RD;
        end
      end
      S_PR_RD: state_d = S_PR_ACC;
      S_PR_ACC: begin
        cmd_o.pr_acc = 1'b1;
        state_d = sts_i.u_last ? S_PR_DIV : S_PR_RD;
      end
      S_PR_DIV: begin
        if (sts_i.ss_zero) begin
          cmd_o.p_zero = 1'b1;
          state_d = S_INS_INIT;
        end else begin
          cmd_o.div_pr = 1'b1;
          state_d = S_DP_WAIT;
        end
      end
      S_DP_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.p_take = 1'b1;
          state_d = S_INS_INIT;
        end
      end
      S_INS_INIT: begin
        cmd_o.ins_init = 1'b1;
        state_d = S_INS_CHK;
      end
      S_INS_CHK: state_d = sts_i.i_zero ? S_INS_PUT : S_INS_CMP;
      S_INS_CMP: begin
        // strictly lower scores move down, so ties keep the earlier movie first
        if (sts_i.ins_less) begin
          cmd_o.ins_shift = 1'b1;
          state_d = S_INS_CHK;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd_o.ins_put = 1'b1;
        if (sts_i.m_last) begin
          state_d = S_OUT;
          ostep_d = O_INIT;
        end else begin
          state_d = S_PR_TRD;
        end
      end
      S_OUT: begin
        case (ostep_q)
          O_INIT: begin
            cmd_o.out_init = 1'b1;
            ostep_d = sts_i.cnt_zero ? O_EMPTY : O_RD;
          end
          O_RD: begin
            cmd_o.list_out = 1'b1;
            ostep_d = O_LD;
          end
          O_LD: begin
            cmd_o.out_load = 1'b1;
            ostep_d = O_WAIT;
          end
          O_EMPTY: begin
            cmd_o.out_empty = 1'b1;
            ostep_d = O_WAIT;
          end
          O_WAIT: begin
            if (sts_i.out_acc) begin
              cmd_o.out_next = 1'b1;
              if (sts_i.out_last) begin
                state_d = S_LOAD;
                ostep_d = O_INIT;
              end else begin
                ostep_d = O_RD;
              end
            end
          end
          default: ostep_d = O_INIT;
        endcase
      end
      default: state_d = S_LOAD;
    endcase
  end

  a_unit_start_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sq_start, cmd_o.div_sim, cmd_o.div_pr}))
    else $error("two iterative units started together");

  a_shift_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins_shift |-> !sts_i.i_zero)
    else $error("insertion shifted past list head");

  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.cnt_zero)
    else $error("result loaded from empty list");

  a_acc_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.out_acc |-> (state_q == S_OUT && ostep_q == O_WAIT))
    else $error("result taken outside output wait");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.div_sim || cmd_o.div_pr) |=> !sts_i.div_done)
    else $error("divider finished too early");

endmodule

FILE: sv/cosine_collab_filter_top_n.sv
// ----------------------------------------------------------------------------
// cosine_collab_filter_top_n
// Ratings load one per cycle while in_stall_o is low. After the last rating
// the input stalls through the similarity loop (with its 23-step square root
// and 40-step divider), then prediction, division and insertion sort; the
// block then emits up to top_n results.
// Reset clears configuration to defaults and the load position to zero.
// ----------------------------------------------------------------------------
module cosine_collab_filter_top_n import cf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [RATING_W-1:0]  rating_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     movie_index_o,
  output logic [SCORE_W-1:0]   predicted_score_o,
  output logic                 empty_res_o,
  output logic                 last_result_o
);

  cf_cmd_t cmd;
  cf_sts_t sts;

  assign in_stall_o = ~cmd.load_en;

  cf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .rating_i          (rating_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .movie_index_o     (movie_index_o),
    .predicted_score_o (predicted_score_o),
    .empty_res_o       (empty_res_o),
    .last_result_o     (last_result_o)
  );

endmodule

FILE: tb/sv/cf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cf_result_checker
// Watches the config port and both channels of the cosine filter, predicts
// the recommendations for every completed rating matrix and compares them
// field by field, in order, with what the block emits.
// ----------------------------------------------------------------------------
module cf_result_checker import cf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [RATING_W-1:0]  rating_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [IDX_W-1:0]     movie_index_i,
  input  logic [SCORE_W-1:0]   predicted_score_i,
  input  logic                 empty_res_i,
  input  logic                 last_result_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic               empty;
    logic               last;
  } rec_t;

  logic [RATING_W-1:0] ratings [DEF_MAX_USERS*DEF_MAX_MOVIES];
  logic [31:0]         load_pos;
  logic [TGT_W-1:0]    tgt_reg;
  logic [CNT_W-1:0]    topn_reg, users_reg, movies_reg;
  rec_t                recs_q[$];

  function automatic int clampi(logic [CNT_W-1:0] v, int hi);
    if (v == 0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cell_at(int u, int m, int mc);
    return longint'(ratings[(u*mc + m) % (DEF_MAX_USERS*DEF_MAX_MOVIES)]);
  endfunction

  // score every unrated movie of the target user, queue the best ones
  task automatic recommend();
    int uc, mc, tn, t, cnt, i;
    longint unsigned dot, na, nb, a, b, s, ws, ss, p;
    longint unsigned sim [DEF_MAX_USERS];
    int              p_idx [DEF_MAX_MOVIES];
    longint unsigned p_sc [DEF_MAX_MOVIES];
    rec_t r;
    uc = clampi(users_reg, DEF_MAX_USERS);
    mc = clampi(movies_reg, DEF_MAX_MOVIES);
    tn = clampi(topn_reg, MAX_RESULTS);
    t  = int'(tgt_reg);
    cnt = 0;
    if (t >= uc) begin
      r = '{idx: '0, score: '0, empty: 1'b1, last: 1'b1};
      recs_q.insert(recs_q.size(), r);
      return;
    end
    for (int u = 0; u < uc; u++) begin
      dot = 0; na = 0; nb = 0;
      for (int m = 0; m < mc; m++) begin
        a = cell_at(t, m, mc);
        b = cell_at(u, m, mc);
        dot += a*b; na += a*a; nb += b*b;
      end
      if (na == 0 || nb == 0) begin
        sim[u] = 0;
      end else begin
        s = (dot << 16) / int_sqrt(na*nb);
        sim[u] = (s > 65536) ? 65536 : s;
      end
    end
    for (int m = 0; m < mc; m++) begin
      if (cell_at(t, m, mc) != 0) continue;
      ws = 0; ss = 0; p = 0;
      for (int u = 0; u < uc; u++) begin
        if (u == t) continue;
        b = cell_at(u, m, mc);
        if (b > 0) begin
          ws += sim[u]*b;
          ss += sim[u];
        end
      end
      if (ss != 0) p = (ws << 8) / ss;
      if (p > 65535) p = 65535;
      // stable insert: descending score, lower index first on ties
      i = cnt;
      while (i > 0 && p_sc[i-1] < p) begin
        p_sc[i]  = p_sc[i-1];
        p_idx[i] = p_idx[i-1];
        i--;
      end
      p_sc[i]  = p;
      p_idx[i] = m;
      cnt++;
    end
    if (cnt == 0) begin
      r = '{idx: '0, score: '0, empty: 1'b1, last: 1'b1};
      recs_q.insert(recs_q.size(), r);
      return;
    end
    if (cnt > tn) cnt = tn;
    for (int k = 0; k < cnt; k++) begin
      r.idx   = IDX_W'(p_idx[k]);
      r.score = SCORE_W'(p_sc[k]);
      r.empty = 1'b0;
      r.last  = (k + 1 == cnt);
      recs_q.insert(recs_q.size(), r);
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int uc, mc;
    rec_t w;
    if (!rst_ni) begin
      load_pos   <= 0;
      tgt_reg    <= '0;
      topn_reg   <= CNT_W'(1);
      users_reg  <= CNT_W'(1);
      movies_reg <= CNT_W'(1);
      recs_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_TARGET: tgt_reg    <= cfg_data_i[TGT_W-1:0];
          CFG_TOP_N:  topn_reg   <= cfg_data_i;
          CFG_USERS:  users_reg  <= cfg_data_i;
          CFG_MOVIES: movies_reg <= cfg_data_i;
          default: ;
        endcase
        load_pos <= 0;
      end
      if (in_valid_i && !in_stall_i) begin
        uc = clampi(users_reg, DEF_MAX_USERS);
        mc = clampi(movies_reg, DEF_MAX_MOVIES);
        if (load_pos >= uc*mc) load_pos = 0;
        ratings[load_pos] = rating_i;
        if (load_pos + 1 >= uc*mc) begin
          load_pos <= 0;
          recommend();
        end else begin
          load_pos <= load_pos + 1;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (recs_q.size() == 0) begin
          report("unexpected result, movie_index", int'(movie_index_i), -1);
        end else begin
          w = recs_q.pop_front();
          if (movie_index_i !== w.idx)
            report("movie_index", int'(movie_index_i), int'(w.idx));
          if (predicted_score_i !== w.score)
            report("predicted_score", int'(predicted_score_i), int'(w.score));
          if (empty_res_i !== w.empty)
            report("empty_res", int'(empty_res_i), int'(w.empty));
          if (last_result_i !== w.last)
            report("last_result", int'(last_result_i), int'(w.last));
        end
      end
      pending_o = recs_q.size();
    end
  end

  initial fail_count_o = 0;

endmodule

FILE: tb/sv/tb_cosine_collab_filter_top_n.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cosine_collab_filter_top_n
// Loads directed and random rating matrices under many register settings,
// with bursty input and a stalling receiver; the checker predicts and
// compares every recommendation.
// ----------------------------------------------------------------------------
module tb_cosine_collab_filter_top_n;
  import cf_pkg::*;

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i, in_stall_o;
  logic [RATING_W-1:0]  rating_i;
  logic                 out_valid_o, out_stall_i;
  logic [IDX_W-1:0]     movie_index_o;
  logic [SCORE_W-1:0]   predicted_score_o;
  logic                 empty_res_o, last_result_o;
  int                   fail_count, pending;
  int                   burst_left;
  int                   items_sent;

  cosine_collab_filter_top_n u_top (.*);

  cf_result_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .rating_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .movie_index_i(movie_index_o), .predicted_score_i(predicted_score_o),
    .empty_res_i(empty_res_o), .last_result_i(last_result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_cosine_collab_filter_top_n: errors");
    $finish;
  end

  // one request, held until taken; gaps come between bursts
  task automatic send_rating(logic [RATING_W-1:0] r);
    in_valid_i <= 1'b1;
    rating_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
    end
  endtask

  // registers only change once everything in flight has drained
  task automatic configure(int tgt, int tn, int uc, int mc);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_TARGET; cfg_data_i <= CFG_W'(tgt);
    @(posedge clk_i);
    cfg_idx_i <= CFG_TOP_N;  cfg_data_i <= CFG_W'(tn);
    @(posedge clk_i);
    cfg_idx_i <= CFG_USERS;  cfg_data_i <= CFG_W'(uc);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MOVIES; cfg_data_i <= CFG_W'(mc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // style: 0 random, 1 identical rows (ties), 2 target row blank, 3 dense
  task automatic send_matrix(int uc, int mc, int tgt, int style, int cut);
    logic [RATING_W-1:0] row [DEF_MAX_MOVIES];
    int u_eff, m_eff, n;
    logic [RATING_W-1:0] r;
    u_eff = (uc == 0) ? 1 : (uc > 64 ? 64 : uc);
    m_eff = (mc == 0) ? 1 : (mc > 64 ? 64 : mc);
    n = 0;
    for (int m = 0; m < m_eff; m++)
      row[m] = ($urandom_range(0, 2) == 0) ? 8'd0 : RATING_W'($urandom_range(1, 255));
    for (int u = 0; u < u_eff; u++) begin
      for (int m = 0; m < m_eff; m++) begin
        if (cut >= 0 && n >= cut) return;
        case (style)
          1: r = (u == tgt) ? ((m == 0) ? 8'd200 : 8'd0) : row[m];
          2: r = (u == tgt) ? 8'd0 : RATING_W'($urandom_range(0, 255));
          3: r = RATING_W'($urandom_range(1, 255));
          default: r = ($urandom_range(0, 9) < 4) ? 8'd0 : RATING_W'($urandom_range(1, 255));
        endcase
        send_rating(r);
        n++;
      end
    end
  endtask

  initial begin
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_TARGET;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    rating_i   <= '0;
    burst_left = 0;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one-by-one matrix, rated then unrated
    send_rating(8'd255);
    send_rating(8'd0);
    configure(0, 64, 1, 64);   send_matrix(1, 64, 0, 2, -1);
    configure(63, 0, 64, 1);   send_matrix(64, 1, 63, 3, -1);
    configure(5, 3, 3, 4);     send_matrix(3, 4, 5, 0, -1);
    configure(2, 127, 0, 100); send_matrix(1, 64, 2, 0, -1);
    configure(0, 4, 3, 4);     send_matrix(3, 4, 0, 1, -1);
    configure(1, 2, 4, 3);     send_matrix(4, 3, 1, 2, -1);
    configure(1, 2, 4, 3);     send_matrix(4, 3, 1, 3, -1);

    while (items_sent < 500) begin
      int uc, mc, tgt, tn, style;
      uc  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) % 12 : $urandom_range(2, 6);
      mc  = $urandom_range(1, 8);
      tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, uc);
      tn  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
      configure(tgt, tn, uc, mc);
      if ($urandom_range(0, 7) == 0) begin
        send_matrix(uc, mc, tgt, 0, $urandom_range(1, 5));
        configure(tgt, tn, uc, mc);
      end
      repeat ($urandom_range(1, 3)) begin
        style = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        send_matrix(uc, mc, tgt, style, -1);
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_cosine_collab_filter_top_n: clean");
    end else begin
      $display("tb_cosine_collab_filter_top_n: errors");
    end
    $finish;
  end

  // receiver: one long hold-off early on, then shifting stall patterns
  initial begin
    int mode;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    repeat (30) @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (4000) @(posedge clk_i);
    out_stall_i <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (200) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          default: out_stall_i <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

endmodule
